@@ sv/tppg_pkg.sv @@
// ----------------------------------------------------------------------------
// Tape playback pulse generator package
// Request codes, symbol encoding, half-period lengths and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tppg_pkg;

    localparam int STORE_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH         = 4;

    localparam int SYM_W  = 10;
    localparam int HALF_W = 10;
    localparam int TICK_W = 10;

    localparam logic [TICK_W-1:0] ELAPSED_MAX = 10'd1023;

    // Half-period lengths in ticks.
    localparam logic [TICK_W-1:0] LEADER_HALF = 10'd500;
    localparam logic [TICK_W-1:0] SYNC_FIRST  = 10'd464;
    localparam logic [TICK_W-1:0] SYNC_MID    = 10'd679;
    localparam logic [TICK_W-1:0] SYNC_SHORT  = 10'd199;
    localparam logic [TICK_W-1:0] SYNC_TAIL   = 10'd250;
    localparam logic [TICK_W-1:0] DATA_ONE    = 10'd500;
    localparam logic [TICK_W-1:0] DATA_ZERO   = 10'd250;

    // Number of half periods in each symbol kind.
    localparam logic [HALF_W-1:0] LEADER_LEN = 10'd1000;
    localparam logic [HALF_W-1:0] SYNC_LEN   = 10'd68;
    localparam logic [HALF_W-1:0] DATA_LEN   = 10'd16;
    localparam logic [HALF_W-1:0] OTHER_LEN  = 10'd1;

    // Positions inside a sync symbol.
    localparam logic [HALF_W-1:0] SYNC_MID_LAST  = 10'd65;
    localparam logic [HALF_W-1:0] SYNC_SHORT_IDX = 10'd66;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_LEADER = 3'd1,
        REQ_SYNC   = 3'd2,
        REQ_DATA   = 3'd3,
        REQ_CLEAR  = 3'd4,
        REQ_PLAY   = 3'd5,
        REQ_STOP   = 3'd6,
        REQ_REWIND = 3'd7
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_LEADER = 2'd0,
        KIND_SYNC   = 2'd1,
        KIND_DATA   = 2'd2
    } sym_kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } sym_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_APPEND = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_PLAY   = 3'd3,
        OP_STOP   = 3'd4,
        OP_REWIND = 3'd5
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        sym_t    sym;
    } cmd_t;

    typedef enum logic {
        BK_RUN  = 1'b0,
        BK_FILL = 1'b1
    } back_state_t;

    function automatic logic [TICK_W-1:0] sym_duration(input sym_t sym,
                                                       input logic [HALF_W-1:0] h);
        logic [TICK_W-1:0] d;
        logic [2:0]        bit_sel;
        // Data bytes go out MSB first, two half periods per bit.
        bit_sel = 3'd7 - h[3:1];
        case (sym.kind)
            KIND_LEADER: d = LEADER_HALF;
            KIND_SYNC: begin
                if (h == '0) begin
                    d = SYNC_FIRST;
                end else if (h <= SYNC_MID_LAST) begin
                    d = SYNC_MID;
                end else if (h == SYNC_SHORT_IDX) begin
                    d = SYNC_SHORT;
                end else begin
                    d = SYNC_TAIL;
                end
            end
            KIND_DATA: d = sym.data[bit_sel] ? DATA_ONE : DATA_ZERO;
            default:   d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [HALF_W-1:0] sym_length(input sym_t sym);
        logic [HALF_W-1:0] len;
        case (sym.kind)
            KIND_LEADER: len = LEADER_LEN;
            KIND_SYNC:   len = SYNC_LEN;
            KIND_DATA:   len = DATA_LEN;
            default:     len = OTHER_LEN;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ sv/tppg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tppg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/tppg_front.sv @@
// ----------------------------------------------------------------------------
// Tape playback front end
// Accepts requests, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tppg_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [2:0]      s_req_type,
    input  wire logic [7:0]      s_data_byte,
    output logic                 cmd_valid,
    output tppg_pkg::cmd_t       cmd,
    input  wire logic            cmd_ready
);

    localparam int QD  = tppg_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    tppg_pkg::cmd_t queue_reg [QD];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;

    tppg_pkg::cmd_t cmd_in;
    logic           push;
    logic           pop;

    // Appends carry the symbol word that goes into the store.
    always_comb begin
        cmd_in.op       = tppg_pkg::OP_REWIND;
        cmd_in.sym.kind = tppg_pkg::KIND_LEADER;
        cmd_in.sym.data = '0;
        case (s_req_type)
            tppg_pkg::REQ_TICK:   cmd_in.op = tppg_pkg::OP_TICK;
            tppg_pkg::REQ_LEADER: cmd_in.op = tppg_pkg::OP_APPEND;
            tppg_pkg::REQ_SYNC: begin
                cmd_in.op       = tppg_pkg::OP_APPEND;
                cmd_in.sym.kind = tppg_pkg::KIND_SYNC;
            end
            tppg_pkg::REQ_DATA: begin
                cmd_in.op       = tppg_pkg::OP_APPEND;
                cmd_in.sym.kind = tppg_pkg::KIND_DATA;
                cmd_in.sym.data = s_data_byte;
            end
            tppg_pkg::REQ_CLEAR:  cmd_in.op = tppg_pkg::OP_CLEAR;
            tppg_pkg::REQ_PLAY:   cmd_in.op = tppg_pkg::OP_PLAY;
            tppg_pkg::REQ_STOP:   cmd_in.op = tppg_pkg::OP_STOP;
            default:              cmd_in.op = tppg_pkg::OP_REWIND;
        endcase
    end

    assign s_ready   = (fill_reg != QCW'(QD));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + QCW'(1);
            2'b01:   fill_next = fill_reg - QCW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ sv/tppg_back.sv @@
// ----------------------------------------------------------------------------
// Tape playback back end
// Executes queued commands against the symbol store and the playback state.
// ----------------------------------------------------------------------------
`default_nettype none

module tppg_back #(
    parameter int STORE_DEPTH = tppg_pkg::STORE_DEPTH_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    input  wire tppg_pkg::cmd_t cmd,
    output logic                cmd_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_cas_level,
    output logic                m_playing,
    output logic                m_accepted
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = $clog2(STORE_DEPTH + 1);
    localparam int HW = tppg_pkg::HALF_W;
    localparam int TW = tppg_pkg::TICK_W;

    tppg_pkg::back_state_t state_reg, state_next;

    logic [PW-1:0]  count_reg, count_next;
    logic [PW-1:0]  pi_reg, pi_next;
    logic [HW-1:0]  half_reg, half_next;
    logic [TW-1:0]  elapsed_reg, elapsed_next;
    logic [TW-1:0]  needed_reg, needed_next;
    logic           level_reg, level_next;
    logic           play_reg, play_next;
    logic           started_reg, started_next;
    logic           at_end_reg, at_end_next;
    logic           cache_valid_reg, cache_valid_next;
    tppg_pkg::sym_t cache_reg, cache_next;

    logic m_valid_reg, m_valid_next;
    logic m_level_reg, m_level_next;
    logic m_playing_reg, m_playing_next;
    logic m_accepted_reg, m_accepted_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [tppg_pkg::SYM_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [tppg_pkg::SYM_W-1:0] ram_rdata;

    tppg_pkg::sym_t sym_cur;
    logic           is_tick;
    logic           need_sym;
    logic           sym_ok;
    logic           out_free;
    logic           exec;
    logic           fill_capture;

    // Tick datapath.
    logic [TW-1:0] dur;
    logic [HW-1:0] len;
    logic [TW-1:0] t_elapsed;
    logic [TW-1:0] t_needed;
    logic          t_started;
    logic          t_fire;

    tppg_ram #(
        .WIDTH (tppg_pkg::SYM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (pi_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // The current symbol is cached; a tick that finds the cache stale waits
    // for the registered store read and then runs with the read data.
    assign sym_cur   = (state_reg == tppg_pkg::BK_FILL) ? tppg_pkg::sym_t'(ram_rdata)
                                                        : cache_reg;
    assign is_tick   = (cmd.op == tppg_pkg::OP_TICK);
    assign need_sym  = is_tick && play_reg && !at_end_reg;
    assign sym_ok    = !need_sym || cache_valid_reg || (state_reg == tppg_pkg::BK_FILL);
    assign out_free  = !m_valid_reg || m_ready;
    assign exec      = cmd_valid && out_free && sym_ok;
    assign cmd_ready = exec;

    always_comb begin
        case (state_reg)
            tppg_pkg::BK_RUN: begin
                if (cmd_valid && need_sym && !cache_valid_reg) begin
                    state_next = tppg_pkg::BK_FILL;
                end else begin
                    state_next = tppg_pkg::BK_RUN;
                end
            end
            default: state_next = tppg_pkg::BK_RUN;
        endcase
    end

    always_comb begin
        case (state_reg)
            tppg_pkg::BK_RUN: begin
                ram_re       = cmd_valid && need_sym && !cache_valid_reg;
                fill_capture = 1'b0;
            end
            default: begin
                ram_re       = 1'b0;
                fill_capture = 1'b1;
            end
        endcase
    end

    always_comb begin
        dur       = tppg_pkg::sym_duration(sym_cur, half_reg);
        len       = tppg_pkg::sym_length(sym_cur);
        t_elapsed = elapsed_reg;
        t_needed  = needed_reg;
        t_started = started_reg;
        if (started_reg && (elapsed_reg != tppg_pkg::ELAPSED_MAX)) begin
            t_elapsed = elapsed_reg + TW'(1);
        end
        // Starting playback loads the first half period without advancing,
        // so that half period plays twice.
        if (play_reg && !started_reg && !at_end_reg) begin
            t_started = 1'b1;
            t_elapsed = '0;
            t_needed  = dur;
        end
        t_fire = t_started ? (t_elapsed > t_needed) : 1'b1;
    end

    always_comb begin
        count_next       = count_reg;
        pi_next          = pi_reg;
        half_next        = half_reg;
        elapsed_next     = elapsed_reg;
        needed_next      = needed_reg;
        level_next       = level_reg;
        play_next        = play_reg;
        started_next     = started_reg;
        at_end_next      = at_end_reg;
        cache_next       = fill_capture ? tppg_pkg::sym_t'(ram_rdata) : cache_reg;
        cache_valid_next = cache_valid_reg || fill_capture;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[AW-1:0];
        ram_wdata        = cmd.sym;
        m_valid_next     = m_valid_reg && !m_ready;
        m_level_next     = m_level_reg;
        m_playing_next   = m_playing_reg;
        m_accepted_next  = m_accepted_reg;

        if (exec) begin
            m_valid_next    = 1'b1;
            m_accepted_next = 1'b1;
            case (cmd.op)
                tppg_pkg::OP_TICK: begin
                    elapsed_next = t_elapsed;
                    if (play_reg) begin
                        started_next = t_started;
                        needed_next  = t_needed;
                        if (t_fire) begin
                            level_next   = !level_reg;
                            elapsed_next = '0;
                            if (!at_end_reg) begin
                                started_next = 1'b1;
                                needed_next  = dur;
                                if ((half_reg + HW'(1)) >= len) begin
                                    half_next        = '0;
                                    pi_next          = pi_reg + PW'(1);
                                    cache_valid_next = 1'b0;
                                    if ((pi_reg + PW'(1)) >= count_reg) begin
                                        at_end_next = 1'b1;
                                    end
                                end else begin
                                    half_next = half_reg + HW'(1);
                                end
                            end else begin
                                started_next = 1'b0;
                                play_next    = 1'b0;
                            end
                        end
                    end
                end
                tppg_pkg::OP_APPEND: begin
                    if (count_reg >= PW'(STORE_DEPTH)) begin
                        m_accepted_next = 1'b0;
                    end else begin
                        ram_we           = 1'b1;
                        count_next       = count_reg + PW'(1);
                        cache_valid_next = 1'b0;
                    end
                end
                tppg_pkg::OP_CLEAR: begin
                    count_next       = '0;
                    pi_next          = '0;
                    half_next        = '0;
                    at_end_next      = 1'b1;
                    cache_valid_next = 1'b0;
                end
                tppg_pkg::OP_PLAY: begin
                    if (!at_end_reg) begin
                        play_next = 1'b1;
                    end
                end
                tppg_pkg::OP_STOP: begin
                    if (play_reg) begin
                        play_next   = 1'b0;
                        at_end_next = 1'b1;
                    end
                end
                default: begin
                    pi_next          = '0;
                    half_next        = '0;
                    at_end_next      = (count_reg == '0);
                    cache_valid_next = 1'b0;
                end
            endcase
            // A tick reports the level if playback was active when it arrived.
            m_level_next   = (is_tick ? play_reg : play_next) && level_next;
            m_playing_next = play_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tppg_pkg::BK_RUN;
            count_reg       <= '0;
            pi_reg          <= '0;
            half_reg        <= '0;
            elapsed_reg     <= '0;
            needed_reg      <= '0;
            level_reg       <= 1'b0;
            play_reg        <= 1'b0;
            started_reg     <= 1'b0;
            at_end_reg      <= 1'b1;
            cache_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pi_reg          <= pi_next;
            half_reg        <= half_next;
            elapsed_reg     <= elapsed_next;
            needed_reg      <= needed_next;
            level_reg       <= level_next;
            play_reg        <= play_next;
            started_reg     <= started_next;
            at_end_reg      <= at_end_next;
            cache_valid_reg <= cache_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cache_reg      <= cache_next;
        m_level_reg    <= m_level_next;
        m_playing_reg  <= m_playing_next;
        m_accepted_reg <= m_accepted_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_cas_level = m_level_reg;
    assign m_playing   = m_playing_reg;
    assign m_accepted  = m_accepted_reg;

endmodule

`default_nettype wire

@@ sv/tape_playback_pulse_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Tape playback pulse generator
// Builds a store of tape symbols and plays them back as a cassette level.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (s_req_type, s_data_byte) and each one
// produces exactly one result on the m_ channel (m_cas_level, m_playing,
// m_accepted), in request order. Ticks stand for CPU cycles: send one per clock.
// A request enters a four-entry command queue and is executed from it into an
// output register, from which its result is presented on the m_ channel.
// Throughput is one request per cycle while the receiver keeps up and no store
// read is pending. While playback runs with a position, the first tick after
// playback moves onto a new symbol, or after an append, clear or rewind, waits
// while the current symbol is read from the store (registered RAM port).
// When the receiver stalls, the result holds in the output register and the
// queue keeps taking requests until it is full; then s_ready drops.
// Reset clears the queue, the output and all playback state; the symbol store
// contents are left undefined and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_playback_pulse_generator_unit #(
    parameter int STORE_DEPTH = tppg_pkg::STORE_DEPTH_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_req_type,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_cas_level,
    output logic            m_playing,
    output logic            m_accepted
);

    tppg_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_ready;

    tppg_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready)
    );

    tppg_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cas_level (m_cas_level),
        .m_playing   (m_playing),
        .m_accepted  (m_accepted)
    );

endmodule

`default_nettype wire

@@ sv/tppg_checker.sv @@
// ----------------------------------------------------------------------------
// Tape playback pulse generator checker
// Port-level checks on pending results, stalls and reset, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tppg_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_cas_level,
    input wire logic       m_playing,
    input wire logic       m_accepted
);

    localparam int MAX_INFLIGHT = tppg_pkg::QUEUE_DEPTH + 1;
    localparam int IW           = $clog2(MAX_INFLIGHT + 1) + 1;

    logic [IW-1:0] inflight_reg, inflight_next;
    logic          in_take;
    logic          out_take;

    assign in_take  = s_valid && s_ready;
    assign out_take = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_take && !out_take) begin
            inflight_next = inflight_reg + IW'(1);
        end else if (!in_take && out_take) begin
            inflight_next = inflight_reg - IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result must hold its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_cas_level, m_playing, m_accepted}))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every result must belong to a request that has not been answered yet.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result without a pending request");

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= IW'(MAX_INFLIGHT))
        else $error("more requests pending than queue and output can hold");

endmodule

bind tape_playback_pulse_generator_unit tppg_checker u_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tape playback pulse generator testbench
// Drives random and directed request streams into the playback unit, predicts
// every result with a cycle-free model of the tape store and playback timing,
// and compares each result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------

module testbench;

    import tppg_pkg::*;

    localparam int STORE_SIZE   = STORE_DEPTH_DEFAULT;
    localparam int TOTAL_ITEMS  = 1450;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 20;

    // Half-period lengths in ticks, and the cap on the tick count.
    localparam logic [9:0] HALF_LONG  = 10'd500;
    localparam logic [9:0] HALF_SHORT = 10'd250;
    localparam logic [9:0] SYNC_LEAD  = 10'd464;
    localparam logic [9:0] SYNC_BODY  = 10'd679;
    localparam logic [9:0] SYNC_GAP   = 10'd199;
    localparam logic [9:0] TICKS_CAP  = 10'd1023;

    typedef struct {
        req_type_t  req;
        logic [7:0] data;
        bit         lazy;
        bit         drain_first;
    } tape_request_t;

    typedef struct packed {
        logic cas_level;
        logic playing;
        logic accepted;
    } tape_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_req_type = REQ_TICK;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_cas_level;
    logic       m_playing;
    logic       m_accepted;

    tape_request_t requests_to_send[$];
    tape_result_t  tape_outputs_due[$];

    int n_accepted = 0;
    int n_done = 0;
    int n_errors = 0;
    int cycle_count = 0;
    int run_limit = 32'h7fffffff;
    bit gen_lazy = 1'b0;
    bit gen_drain = 1'b0;

    // Playback state as the predictor sees it.
    sym_t       tape_store [STORE_SIZE];
    logic [8:0] sym_count;
    logic [8:0] sym_pos;
    logic [9:0] half_pos;
    logic [9:0] ticks_seen;
    logic [9:0] ticks_due;
    logic       level_q;
    logic       motor_on;
    logic       armed;
    logic       no_position;

    tape_playback_pulse_generator_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cas_level (m_cas_level),
        .m_playing   (m_playing),
        .m_accepted  (m_accepted)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", n_done, msg);
        n_errors++;
    endtask

    function automatic void reset_tape_model();
        sym_count   = '0;
        sym_pos     = '0;
        half_pos    = '0;
        ticks_seen  = '0;
        ticks_due   = '0;
        level_q     = 1'b0;
        motor_on    = 1'b0;
        armed       = 1'b0;
        no_position = 1'b1;
    endfunction

    function automatic logic [9:0] half_length(input sym_t s, input logic [9:0] h);
        case (s.kind)
            KIND_LEADER: return HALF_LONG;
            KIND_SYNC: begin
                if (h == 10'd0) return SYNC_LEAD;
                if (h <= 10'd65) return SYNC_BODY;
                if (h == 10'd66) return SYNC_GAP;
                return HALF_SHORT;
            end
            KIND_DATA: return s.data[3'd7 - h[3:1]] ? HALF_LONG : HALF_SHORT;
            default: return 10'd0;
        endcase
    endfunction

    function automatic logic [9:0] halves_in(input sym_t s);
        case (s.kind)
            KIND_LEADER: return 10'd1000;
            KIND_SYNC:   return 10'd68;
            KIND_DATA:   return 10'd16;
            default:     return 10'd1;
        endcase
    endfunction

    function automatic sym_t symbol_at_position();
        if (sym_pos < STORE_SIZE) return tape_store[sym_pos];
        return '0;
    endfunction

    function automatic void step_position();
        half_pos++;
        if (half_pos >= halves_in(symbol_at_position())) begin
            half_pos = '0;
            sym_pos++;
            if (sym_pos >= sym_count) no_position = 1'b1;
        end
    endfunction

    // Applies one request to the playback state and returns its result.
    function automatic tape_result_t play_tape_request(input req_type_t req,
                                                       input logic [7:0] data_in);
        tape_result_t r;
        sym_t         entry;
        logic         was_running;
        logic         fire;
        r.accepted  = 1'b1;
        r.cas_level = 1'b0;
        case (req)
            REQ_TICK: begin
                was_running = motor_on;
                if (armed && ticks_seen < TICKS_CAP) ticks_seen++;
                if (motor_on) begin
                    if (!armed && !no_position) begin
                        armed      = 1'b1;
                        ticks_seen = '0;
                        ticks_due  = half_length(symbol_at_position(), half_pos);
                    end
                    fire = armed ? (ticks_seen > ticks_due) : 1'b1;
                    if (fire) begin
                        level_q    = ~level_q;
                        ticks_seen = '0;
                        if (!no_position) begin
                            armed     = 1'b1;
                            ticks_due = half_length(symbol_at_position(), half_pos);
                            step_position();
                        end else begin
                            armed    = 1'b0;
                            motor_on = 1'b0;
                        end
                    end
                end
                r.cas_level = was_running & level_q;
            end
            REQ_LEADER, REQ_SYNC, REQ_DATA: begin
                if (sym_count >= STORE_SIZE) begin
                    r.accepted = 1'b0;
                end else begin
                    entry.kind = (req == REQ_LEADER) ? KIND_LEADER :
                                 (req == REQ_SYNC) ? KIND_SYNC : KIND_DATA;
                    entry.data = (req == REQ_DATA) ? data_in : 8'h00;
                    tape_store[sym_count] = entry;
                    sym_count++;
                end
                r.cas_level = motor_on & level_q;
            end
            REQ_CLEAR: begin
                sym_count   = '0;
                sym_pos     = '0;
                half_pos    = '0;
                no_position = 1'b1;
                r.cas_level = motor_on & level_q;
            end
            REQ_PLAY: begin
                if (!no_position) motor_on = 1'b1;
                r.cas_level = motor_on & level_q;
            end
            REQ_STOP: begin
                if (motor_on) begin
                    motor_on    = 1'b0;
                    no_position = 1'b1;
                end
            end
            default: begin
                sym_pos     = '0;
                half_pos    = '0;
                no_position = (sym_count == 0);
                r.cas_level = motor_on & level_q;
            end
        endcase
        r.playing = motor_on;
        return r;
    endfunction

    function automatic void queue_request(input req_type_t req, input logic [7:0] data);
        tape_request_t r;
        r.req         = req;
        r.data        = data;
        r.lazy        = gen_lazy;
        r.drain_first = gen_drain;
        gen_drain     = 1'b0;
        requests_to_send.push_back(r);
    endfunction

    function automatic void queue_ticks(input int n);
        for (int i = 0; i < n; i++) queue_request(REQ_TICK, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_symbol();
        int p;
        p = $urandom_range(0, 19);
        if (p < 14) queue_request(REQ_DATA, 8'($urandom_range(0, 255)));
        else if (p < 19) queue_request(REQ_SYNC, 8'($urandom_range(0, 255)));
        else queue_request(REQ_LEADER, 8'($urandom_range(0, 255)));
    endfunction

    function automatic int draw_run();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(0, 30);
        if (p < 95) return $urandom_range(30, 120);
        return $urandom_range(120, 400);
    endfunction

    initial begin
        int episode;
        int pick;
        int n;
        int mid;

        // Directed opening: ignored commands, field extremes, and the cases where
        // the position is dropped under a running or just-started playback.
        queue_request(REQ_PLAY,   8'h00);
        queue_request(REQ_STOP,   8'hFF);
        queue_request(REQ_REWIND, 8'h00);
        queue_request(REQ_TICK,   8'hFF);
        queue_request(REQ_DATA,   8'h00);
        queue_request(REQ_DATA,   8'hFF);
        queue_request(REQ_LEADER, 8'hFF);
        queue_request(REQ_SYNC,   8'h00);
        queue_request(REQ_CLEAR,  8'hFF);
        queue_request(REQ_DATA,   8'h5A);
        queue_request(REQ_REWIND, 8'hFF);
        queue_request(REQ_PLAY,   8'hFF);
        queue_request(REQ_CLEAR,  8'h00);
        queue_request(REQ_TICK,   8'h00);
        queue_request(REQ_DATA,   8'hA5);
        queue_request(REQ_REWIND, 8'h00);
        queue_request(REQ_PLAY,   8'h00);
        queue_request(REQ_TICK,   8'h00);
        queue_request(REQ_STOP,   8'h00);
        queue_request(REQ_TICK,   8'h00);
        queue_request(REQ_REWIND, 8'h00);
        queue_request(REQ_PLAY,   8'h00);
        queue_request(REQ_TICK,   8'h00);
        queue_request(REQ_CLEAR,  8'h00);
        // Playback that loses its position before the first tick ends at once.
        queue_request(REQ_DATA,   8'h3C);
        queue_request(REQ_REWIND, 8'h00);
        queue_request(REQ_PLAY,   8'h00);
        queue_request(REQ_CLEAR,  8'h00);
        queue_request(REQ_TICK,   8'h00);
        queue_request(REQ_TICK,   8'h00);

        episode = 0;
        while (requests_to_send.size() < TOTAL_ITEMS) begin
            gen_lazy  = ($urandom_range(0, 3) == 0);
            gen_drain = (episode == 0) || ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 99);
            if (episode == 2) begin
                // Play into a sync symbol far enough for its first toggle.
                gen_lazy = 1'b0;
                queue_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                queue_request(REQ_SYNC, 8'($urandom_range(0, 255)));
                queue_request(REQ_DATA, 8'($urandom_range(0, 255)));
                queue_request(REQ_REWIND, 8'($urandom_range(0, 255)));
                queue_request(REQ_PLAY, 8'($urandom_range(0, 255)));
                queue_ticks(480);
            end else if (episode == 5) begin
                // Overfill the store so the last appends are dropped.
                queue_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                repeat (STORE_SIZE + 3) queue_symbol();
                queue_request(REQ_REWIND, 8'($urandom_range(0, 255)));
                queue_request(REQ_PLAY, 8'($urandom_range(0, 255)));
                queue_ticks(30);
            end else if (pick < 75) begin
                if ($urandom_range(0, 9) < 7) queue_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                n = $urandom_range(1, 4);
                repeat (n) queue_symbol();
                queue_request(REQ_REWIND, 8'($urandom_range(0, 255)));
                queue_request(REQ_PLAY, 8'($urandom_range(0, 255)));
                queue_ticks(draw_run());
                n = $urandom_range(0, 3);
                repeat (n) begin
                    mid = $urandom_range(0, 9);
                    case (mid)
                        0, 1, 2: queue_symbol();
                        3, 4:    queue_request(REQ_STOP, 8'($urandom_range(0, 255)));
                        5, 6: begin
                            queue_request(REQ_REWIND, 8'($urandom_range(0, 255)));
                            queue_request(REQ_PLAY, 8'($urandom_range(0, 255)));
                        end
                        7:       queue_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                        8:       queue_request(REQ_PLAY, 8'($urandom_range(0, 255)));
                        default: queue_request(REQ_REWIND, 8'($urandom_range(0, 255)));
                    endcase
                    queue_ticks(draw_run());
                end
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    mid = $urandom_range(0, 7);
                    if (req_type_t'(mid) == REQ_TICK) queue_ticks($urandom_range(0, 5));
                    else queue_request(req_type_t'(mid), 8'($urandom_range(0, 255)));
                end
            end
            episode++;
        end

        run_limit = requests_to_send.size() * 60 + 200000;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (requests_to_send.size() != 0 || s_valid || n_done != n_accepted);
        repeat (SETTLE) @(negedge aclk);

        if (tape_outputs_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", tape_outputs_due.size()));
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > run_limit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Request driver. A request may hold the sender off until all results are in.
    always @(posedge aclk) begin : driver
        tape_request_t next;
        int            tx_gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) n_accepted++;
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (requests_to_send.size() != 0 &&
                             !(requests_to_send[0].drain_first && n_accepted != n_done)) begin
                    next = requests_to_send.pop_front();
                    s_valid     <= 1'b1;
                    s_req_type  <= next.req;
                    s_data_byte <= next.data;
                    tx_gap = next.lazy ? $urandom_range(0, 8) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver, with one long hold-off that backs up the input side.
    always @(posedge aclk) begin : receiver
        int rx_stall;
        int rx_hold;
        int rx_cycles;
        int rx_taken;
        bit rx_lazy;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall  = 0;
            rx_hold   = 0;
            rx_cycles = 0;
            rx_taken  = 0;
            rx_lazy   = 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == HOLD_START) rx_hold = HOLD_CYCLES;
            if (m_valid && m_ready) begin
                rx_taken++;
                if (rx_taken % 32 == 0) rx_lazy = ($urandom_range(0, 3) == 0);
                rx_stall = rx_lazy ? $urandom_range(0, 8) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Checks each result against the oldest prediction, then predicts for the
    // request taken at this edge, so a request never matches its own-edge result.
    always @(posedge aclk) begin : monitor
        tape_result_t want;
        if (!aresetn) begin
            reset_tape_model();
        end else begin
            if (m_valid && m_ready) begin
                n_done <= n_done + 1;
                if (tape_outputs_due.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = tape_outputs_due.pop_front();
                    if (m_cas_level !== want.cas_level)
                        report_mismatch($sformatf("cas_level %b, want %b",
                                                  m_cas_level, want.cas_level));
                    if (m_playing !== want.playing)
                        report_mismatch($sformatf("playing %b, want %b",
                                                  m_playing, want.playing));
                    if (m_accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %b, want %b",
                                                  m_accepted, want.accepted));
                end
            end
            if (s_valid && s_ready)
                tape_outputs_due.push_back(play_tape_request(req_type_t'(s_req_type),
                                                             s_data_byte));
        end
    end

endmodule

@@ sim.f @@
sv/tppg_pkg.sv
sv/tppg_ram.sv
sv/tppg_front.sv
sv/tppg_back.sv
sv/tape_playback_pulse_generator_unit.sv
sv/tppg_checker.sv
bench/testbench.sv
